[rtl/core/clock_system_tick_distributor_defines.svh]
// Assertion macros shared by the clock tick distributor checkers.
`ifndef CLOCK_SYSTEM_TICK_DISTRIBUTOR_DEFINES_SVH
`define CLOCK_SYSTEM_TICK_DISTRIBUTOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CSTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CSTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/cstd_pkg.sv]
// Shared types, codes and widths of the clock tick distributor.
package cstd_pkg;

   localparam int PERIOD_BITS_DEF = 24;

   localparam int NS_W    = 44;
   localparam int TICK_W  = 32;
   localparam int CYC_W   = 16;
   localparam int SHIFT_W = 2;
   localparam int FRAC_W  = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // item layouts on the stream ports
   localparam int REQ_DATA_W      = 24;
   localparam int REQ_CPU_OFF_BIT = 16;
   localparam int REQ_OSC_OFF_BIT = 17;
   localparam int REQ_SCG0_BIT    = 18;
   localparam int REQ_SCG1_BIT    = 19;
   localparam int RSP_USED_W      = NS_W + 5 * TICK_W + CYC_W;
   localparam int RSP_DATA_W      = 224;
   localparam int RSP_PAD_W       = RSP_DATA_W - RSP_USED_W;

   localparam logic [NS_W-1:0]   NS_MAX   = {NS_W{1'b1}};
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   localparam int DCO_PERIOD_RST   = 1250;
   localparam int XT2_PERIOD_RST   = 0;
   localparam int LFXT1_PERIOD_RST = 30517;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DCO_PERIOD     = 3'd0,
      CSR_XT2_PERIOD     = 3'd1,
      CSR_LFXT1_PERIOD   = 3'd2,
      CSR_MCLK_SOURCE    = 3'd3,
      CSR_SMCLK_SOURCE   = 3'd4,
      CSR_DIVIDER_SHIFTS = 3'd5,
      CSR_XT2_OFF        = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MCLK_DCO     = 2'd0,
      MCLK_DCO_ALT = 2'd1,
      MCLK_XT2     = 2'd2,
      MCLK_LFXT1   = 2'd3
   } mclk_src_type;

   localparam logic SMCLK_DCO = 1'b0;
   localparam logic SMCLK_XT2 = 1'b1;

   typedef enum logic [1:0] {
      OSC_LFXT1 = 2'd0,
      OSC_XT2   = 2'd1,
      OSC_DCO   = 2'd2
   } osc_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_OSC,
      ST_WAIT,
      ST_FIN
   } ctl_state_type;

   typedef struct packed {
      logic    capture;
      logic    mul;
      logic    sat;
      logic    div_start;
      logic    div_commit;
      logic    skip;
      osc_type osc;
      logic    finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_done;
      logic out_free;
   } ctl_status_type;

endpackage

[rtl/core/cstd_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module cstd_div #(
   parameter int DIVISOR_W  = cstd_pkg::PERIOD_BITS_DEF,
   parameter int DIVIDEND_W = cstd_pkg::NS_W + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  part_ff, part_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      // quo_ff shifts the dividend out at the top and the quotient in at the bottom
      trial = {part_ff, quo_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, divisor};
      diff  = trial - {1'b0, divisor};
      quo_in  = quo_ff;
      part_in = part_ff;
      cnt_in  = cnt_ff;
      done_in = (cnt_ff == CNT_W'(1));
      if (start) begin
         quo_in  = dividend;
         part_in = '0;
         cnt_in  = CNT_W'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         part_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      part_ff <= part_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = part_ff;

endmodule

[rtl/core/cstd_dp.sv]
// Datapath: settings, time scaling, oscillator remainders, dividers, result register.
module cstd_dp #(
   parameter int PERIOD_BITS = cstd_pkg::PERIOD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cstd_pkg::ctl_cmd_type               cmd,
   output cstd_pkg::ctl_status_type            status,
   input  logic [cstd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_valid,
   input  logic [cstd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cstd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cstd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int NS_W    = cstd_pkg::NS_W;
   localparam int TICK_W  = cstd_pkg::TICK_W;
   localparam int CYC_W   = cstd_pkg::CYC_W;
   localparam int SHIFT_W = cstd_pkg::SHIFT_W;
   localparam int FRAC_W  = cstd_pkg::FRAC_W;
   localparam int SCYC_W  = CYC_W + (1 << SHIFT_W) - 1;
   localparam int PROD_W  = SCYC_W + PERIOD_BITS;
   localparam int SAT_W   = (PROD_W > NS_W) ? PROD_W : NS_W;
   localparam int ACC_W   = ((NS_W > PERIOD_BITS) ? NS_W : PERIOD_BITS) + 1;
   localparam int SUM_W   = TICK_W + 1;
   localparam int MASK_W  = FRAC_W + 1;
   localparam int DIVR_W  = FRAC_W + TICK_W;

   // fraction in the upper bits, saturated divided ticks in the lower bits
   function automatic logic [DIVR_W-1:0] clk_div(input logic [FRAC_W-1:0]  frac,
                                                input logic [TICK_W-1:0]  ticks,
                                                input logic [SHIFT_W-1:0] shift);
      logic [SUM_W-1:0]  sum;
      logic [SUM_W-1:0]  shifted;
      logic [MASK_W-1:0] mask;
      sum     = {1'b0, ticks} + SUM_W'(frac);
      shifted = sum >> shift;
      mask    = (MASK_W'(1) << shift) - MASK_W'(1);
      return {sum[FRAC_W-1:0] & mask[FRAC_W-1:0],
              shifted[TICK_W] ? cstd_pkg::TICK_MAX : shifted[TICK_W-1:0]};
   endfunction

   // settings
   logic [PERIOD_BITS-1:0] dco_period_ff, dco_period_in;
   logic [PERIOD_BITS-1:0] xt2_period_ff, xt2_period_in;
   logic [PERIOD_BITS-1:0] lfxt1_period_ff, lfxt1_period_in;
   logic [1:0]             mclk_source_ff, mclk_source_in;
   logic                   smclk_source_ff, smclk_source_in;
   logic [5:0]             divider_shifts_ff, divider_shifts_in;
   logic                   xt2_off_ff, xt2_off_in;

   // captured item
   logic [CYC_W-1:0] cycles_ff, cycles_in;
   logic             cpu_off_ff, cpu_off_in;
   logic             osc_off_ff, osc_off_in;
   logic             scg0_ff, scg0_in;
   logic             scg1_ff, scg1_in;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [NS_W-1:0]   ns_ff, ns_in;

   logic [PERIOD_BITS-1:0] lf_rem_ff, lf_rem_in;
   logic [PERIOD_BITS-1:0] xt2_rem_ff, xt2_rem_in;
   logic [PERIOD_BITS-1:0] dco_rem_ff, dco_rem_in;
   logic [TICK_W-1:0]      lf_ticks_ff, lf_ticks_in;
   logic [TICK_W-1:0]      xt2_ticks_ff, xt2_ticks_in;
   logic [TICK_W-1:0]      dco_ticks_ff, dco_ticks_in;
   logic [FRAC_W-1:0]      aclk_frac_ff, aclk_frac_in;
   logic [FRAC_W-1:0]      smclk_frac_ff, smclk_frac_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cstd_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [SHIFT_W-1:0]     aux_shift, main_shift, sub_shift;
   logic [PERIOD_BITS-1:0] mclk_period;
   logic [SCYC_W-1:0]      scaled_cycles;
   logic [SAT_W-1:0]       prod_ext;
   logic                   run_lf, run_xt2, run_dco;
   logic [PERIOD_BITS-1:0] sel_rem, sel_period;
   logic                   sel_run;
   logic [ACC_W-1:0]       div_dividend, div_quo;
   logic [PERIOD_BITS-1:0] div_rem;
   logic                   div_done;
   logic [TICK_W-1:0]      div_ticks;
   logic [DIVR_W-1:0]      aclk_res, smclk_res;
   logic [TICK_W-1:0]      smclk_src_ticks, smclk_ticks;
   logic [CYC_W-1:0]       mclk_ticks;

   always_comb begin
      aux_shift  = divider_shifts_ff[1:0];
      main_shift = divider_shifts_ff[3:2];
      sub_shift  = divider_shifts_ff[5:4];

      case (cstd_pkg::mclk_src_type'(mclk_source_ff))
         cstd_pkg::MCLK_XT2:   mclk_period = xt2_period_ff;
         cstd_pkg::MCLK_LFXT1: mclk_period = lfxt1_period_ff;
         default:              mclk_period = dco_period_ff;
      endcase
      scaled_cycles = SCYC_W'(cycles_ff) << main_shift;
      prod_ext      = SAT_W'(prod_ff);

      // gating rules per oscillator
      run_lf  = !osc_off_ff
             || (mclk_source_ff == cstd_pkg::MCLK_LFXT1 && !cpu_off_ff);
      run_xt2 = !xt2_off_ff
             || (mclk_source_ff == cstd_pkg::MCLK_XT2 && !cpu_off_ff)
             || (smclk_source_ff == cstd_pkg::SMCLK_XT2);
      run_dco = !scg0_ff
             || ((mclk_source_ff == cstd_pkg::MCLK_DCO
                  || mclk_source_ff == cstd_pkg::MCLK_DCO_ALT) && !cpu_off_ff)
             || (smclk_source_ff == cstd_pkg::SMCLK_DCO);

      case (cmd.osc)
         cstd_pkg::OSC_LFXT1: begin
            sel_rem    = lf_rem_ff;
            sel_period = lfxt1_period_ff;
            sel_run    = run_lf;
         end
         cstd_pkg::OSC_XT2: begin
            sel_rem    = xt2_rem_ff;
            sel_period = xt2_period_ff;
            sel_run    = run_xt2;
         end
         cstd_pkg::OSC_DCO: begin
            sel_rem    = dco_rem_ff;
            sel_period = dco_period_ff;
            sel_run    = run_dco;
         end
         default: begin
            sel_rem    = '0;
            sel_period = '0;
            sel_run    = 1'b0;
         end
      endcase
      div_dividend = ACC_W'(ns_ff) + ACC_W'(sel_rem);
      div_ticks    = (|div_quo[ACC_W-1:TICK_W]) ? cstd_pkg::TICK_MAX : div_quo[TICK_W-1:0];

      smclk_src_ticks = (smclk_source_ff == cstd_pkg::SMCLK_XT2) ? xt2_ticks_ff : dco_ticks_ff;
      aclk_res        = clk_div(aclk_frac_ff, lf_ticks_ff, aux_shift);
      smclk_res       = clk_div(smclk_frac_ff, smclk_src_ticks, sub_shift);
      smclk_ticks     = scg1_ff ? '0 : smclk_res[TICK_W-1:0];
      mclk_ticks      = cpu_off_ff ? '0 : cycles_ff;
   end

   // next values
   always_comb begin
      dco_period_in     = dco_period_ff;
      xt2_period_in     = xt2_period_ff;
      lfxt1_period_in   = lfxt1_period_ff;
      mclk_source_in    = mclk_source_ff;
      smclk_source_in   = smclk_source_ff;
      divider_shifts_in = divider_shifts_ff;
      xt2_off_in        = xt2_off_ff;
      if (csr_valid) begin
         case (cstd_pkg::csr_index_type'(csr_index))
            cstd_pkg::CSR_DCO_PERIOD:     dco_period_in     = csr_wdata[PERIOD_BITS-1:0];
            cstd_pkg::CSR_XT2_PERIOD:     xt2_period_in     = csr_wdata[PERIOD_BITS-1:0];
            cstd_pkg::CSR_LFXT1_PERIOD:   lfxt1_period_in   = csr_wdata[PERIOD_BITS-1:0];
            cstd_pkg::CSR_MCLK_SOURCE:    mclk_source_in    = csr_wdata[1:0];
            cstd_pkg::CSR_SMCLK_SOURCE:   smclk_source_in   = csr_wdata[0];
            cstd_pkg::CSR_DIVIDER_SHIFTS: divider_shifts_in = csr_wdata[5:0];
            cstd_pkg::CSR_XT2_OFF:        xt2_off_in        = csr_wdata[0];
            default: ;
         endcase
      end

      cycles_in  = cycles_ff;
      cpu_off_in = cpu_off_ff;
      osc_off_in = osc_off_ff;
      scg0_in    = scg0_ff;
      scg1_in    = scg1_ff;
      if (cmd.capture) begin
         cycles_in  = req_tdata[CYC_W-1:0];
         cpu_off_in = req_tdata[cstd_pkg::REQ_CPU_OFF_BIT];
         osc_off_in = req_tdata[cstd_pkg::REQ_OSC_OFF_BIT];
         scg0_in    = req_tdata[cstd_pkg::REQ_SCG0_BIT];
         scg1_in    = req_tdata[cstd_pkg::REQ_SCG1_BIT];
      end

      prod_in = cmd.mul ? PROD_W'(scaled_cycles) * PROD_W'(mclk_period) : prod_ff;
      ns_in   = ns_ff;
      if (cmd.sat) begin
         ns_in = (prod_ext > SAT_W'(cstd_pkg::NS_MAX)) ? cstd_pkg::NS_MAX : prod_ext[NS_W-1:0];
      end

      lf_rem_in    = lf_rem_ff;
      xt2_rem_in   = xt2_rem_ff;
      dco_rem_in   = dco_rem_ff;
      lf_ticks_in  = lf_ticks_ff;
      xt2_ticks_in = xt2_ticks_ff;
      dco_ticks_in = dco_ticks_ff;
      if (cmd.div_commit) begin
         case (cmd.osc)
            cstd_pkg::OSC_LFXT1: begin
               lf_rem_in   = div_rem;
               lf_ticks_in = div_ticks;
            end
            cstd_pkg::OSC_XT2: begin
               xt2_rem_in   = div_rem;
               xt2_ticks_in = div_ticks;
            end
            cstd_pkg::OSC_DCO: begin
               dco_rem_in   = div_rem;
               dco_ticks_in = div_ticks;
            end
            default: ;
         endcase
      end else if (cmd.skip) begin
         // stopped or absent oscillator: no ticks, remainder held
         case (cmd.osc)
            cstd_pkg::OSC_LFXT1: lf_ticks_in  = '0;
            cstd_pkg::OSC_XT2:   xt2_ticks_in = '0;
            cstd_pkg::OSC_DCO:   dco_ticks_in = '0;
            default: ;
         endcase
      end

      aclk_frac_in  = aclk_frac_ff;
      smclk_frac_in = smclk_frac_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (cmd.finish) begin
         aclk_frac_in = aclk_res[DIVR_W-1:TICK_W];
         if (!scg1_ff) begin
            smclk_frac_in = smclk_res[DIVR_W-1:TICK_W];
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{cstd_pkg::RSP_PAD_W{1'b0}}, smclk_ticks, aclk_res[TICK_W-1:0],
                         mclk_ticks, dco_ticks_ff, xt2_ticks_ff, lf_ticks_ff, ns_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dco_period_ff     <= PERIOD_BITS'(cstd_pkg::DCO_PERIOD_RST);
         xt2_period_ff     <= PERIOD_BITS'(cstd_pkg::XT2_PERIOD_RST);
         lfxt1_period_ff   <= PERIOD_BITS'(cstd_pkg::LFXT1_PERIOD_RST);
         mclk_source_ff    <= cstd_pkg::MCLK_DCO;
         smclk_source_ff   <= cstd_pkg::SMCLK_DCO;
         divider_shifts_ff <= '0;
         xt2_off_ff        <= 1'b1;
         lf_rem_ff         <= '0;
         xt2_rem_ff        <= '0;
         dco_rem_ff        <= '0;
         aclk_frac_ff      <= '0;
         smclk_frac_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         dco_period_ff     <= dco_period_in;
         xt2_period_ff     <= xt2_period_in;
         lfxt1_period_ff   <= lfxt1_period_in;
         mclk_source_ff    <= mclk_source_in;
         smclk_source_ff   <= smclk_source_in;
         divider_shifts_ff <= divider_shifts_in;
         xt2_off_ff        <= xt2_off_in;
         lf_rem_ff         <= lf_rem_in;
         xt2_rem_ff        <= xt2_rem_in;
         dco_rem_ff        <= dco_rem_in;
         aclk_frac_ff      <= aclk_frac_in;
         smclk_frac_ff     <= smclk_frac_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cycles_ff    <= cycles_in;
      cpu_off_ff   <= cpu_off_in;
      osc_off_ff   <= osc_off_in;
      scg0_ff      <= scg0_in;
      scg1_ff      <= scg1_in;
      prod_ff      <= prod_in;
      ns_ff        <= ns_in;
      lf_ticks_ff  <= lf_ticks_in;
      xt2_ticks_ff <= xt2_ticks_in;
      dco_ticks_ff <= dco_ticks_in;
      rsp_data_ff  <= rsp_data_in;
   end

   cstd_div #(
      .DIVISOR_W  (PERIOD_BITS),
      .DIVIDEND_W (ACC_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (sel_period),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign status.div_needed = sel_run && (sel_period != '0);
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/cstd_ctl.sv]
// Controller: sequences capture, scaling, the three shared divisions and the result.
module cstd_ctl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  cstd_pkg::ctl_status_type status,
   output cstd_pkg::ctl_cmd_type    cmd
);

   cstd_pkg::ctl_state_type state_ff, state_in;
   cstd_pkg::osc_type       osc_ff, osc_in;
   cstd_pkg::osc_type       osc_next;
   logic                    osc_last;

   always_comb begin
      case (osc_ff)
         cstd_pkg::OSC_LFXT1: osc_next = cstd_pkg::OSC_XT2;
         cstd_pkg::OSC_XT2:   osc_next = cstd_pkg::OSC_DCO;
         default:             osc_next = cstd_pkg::OSC_LFXT1;
      endcase
      osc_last = (osc_ff == cstd_pkg::OSC_DCO);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      osc_in   = osc_ff;
      case (state_ff)
         cstd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = cstd_pkg::ST_MUL;
            end
         end
         cstd_pkg::ST_MUL: state_in = cstd_pkg::ST_SAT;
         cstd_pkg::ST_SAT: begin
            state_in = cstd_pkg::ST_OSC;
            osc_in   = cstd_pkg::OSC_LFXT1;
         end
         cstd_pkg::ST_OSC: begin
            if (status.div_needed) begin
               state_in = cstd_pkg::ST_WAIT;
            end else begin
               state_in = osc_last ? cstd_pkg::ST_FIN : cstd_pkg::ST_OSC;
               osc_in   = osc_next;
            end
         end
         cstd_pkg::ST_WAIT: begin
            if (status.div_done) begin
               state_in = osc_last ? cstd_pkg::ST_FIN : cstd_pkg::ST_OSC;
               osc_in   = osc_next;
            end
         end
         cstd_pkg::ST_FIN: begin
            if (status.out_free) begin
               state_in = cstd_pkg::ST_IDLE;
            end
         end
         default: state_in = cstd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.osc    = osc_ff;
      req_tready = (state_ff == cstd_pkg::ST_IDLE);
      case (state_ff)
         cstd_pkg::ST_IDLE: cmd.capture = req_tvalid;
         cstd_pkg::ST_MUL:  cmd.mul     = 1'b1;
         cstd_pkg::ST_SAT:  cmd.sat     = 1'b1;
         cstd_pkg::ST_OSC: begin
            cmd.div_start = status.div_needed;
            cmd.skip      = !status.div_needed;
         end
         cstd_pkg::ST_WAIT: cmd.div_commit = status.div_done;
         cstd_pkg::ST_FIN:  cmd.finish     = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cstd_pkg::ST_IDLE;
         osc_ff   <= cstd_pkg::OSC_LFXT1;
      end else begin
         state_ff <= state_in;
         osc_ff   <= osc_in;
      end
   end

endmodule

[rtl/core/clock_system_tick_distributor.sv]
// Clock system tick distributor: one item of main-clock cycles in, one item of ticks out.
//
// req_* carries one item per processor step: the main-clock cycle count and the
// four low-power flags. rsp_* returns one item per request: elapsed time in ns
// and the ticks of each oscillator and derived clock. csr_* writes settings
// (always ready); write it only while no item is in flight.
// From req accept to rsp_tvalid the controller steps through MUL and SAT, then
// OSC for each oscillator in turn (with WAIT while the divider runs), then FIN;
// a new item is taken only once the last one's result is registered. The one
// bit-serial divider, 45 quotient bits per oscillator (time plus remainder), is
// used only by the oscillators that run with a nonzero period and is shared by
// the three oscillators in turn; one multiplier scales the count.
// Results sit in an output register: the next item is accepted while one waits,
// and a stalled receiver only holds up the block when its next result is done.
// Reset (synchronous, active high) restores the default periods and sources,
// clears the oscillator remainders and divider fractions and drops rsp_tvalid.
module clock_system_tick_distributor #(
   parameter int PERIOD_BITS = cstd_pkg::PERIOD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mclk_cycles[15:0], cpu_off[16], osc_off[17], scg0[18], scg1[19], zero[23:20]
   input  logic [cstd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // elapsed_ns[43:0], lfxt1_ticks[75:44], xt2_ticks[107:76], dco_ticks[139:108],
   // mclk_ticks[155:140], aclk_ticks[187:156], smclk_ticks[219:188], zero[223:220]
   output logic [cstd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cstd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cstd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   cstd_pkg::ctl_cmd_type    cmd;
   cstd_pkg::ctl_status_type status;

   assign csr_ready = 1'b1;

   cstd_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cstd_dp #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/cstd_checker.sv]
// Port-level checks of the clock tick distributor, bound to the top level.
`include "clock_system_tick_distributor_defines.svh"

module cstd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cstd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a held result keeps its payload
   `CSTD_ASSERT_NEXT(a_rsp_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp item changed while stalled")

   // one item in work at a time
   `CSTD_ASSERT_NEXT(a_req_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "req taken twice in a row")

   // no result is raised straight after its item is taken
   `CSTD_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "rsp raised right after accept")

   `CSTD_ASSERT_NOW(a_rsp_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[cstd_pkg::RSP_DATA_W-1:cstd_pkg::RSP_USED_W] == '0, "rsp pad bits not zero")

endmodule

bind clock_system_tick_distributor cstd_checker u_cstd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[verif/tb_clock_system_tick_distributor.sv]
// Testbench for the clock system tick distributor: random and directed items, self-checking.
`timescale 1ns / 1ps

module tb_clock_system_tick_distributor;

   localparam int PER_W      = cstd_pkg::PERIOD_BITS_DEF;
   localparam int CYC_W      = cstd_pkg::CYC_W;
   localparam int TICK_W     = cstd_pkg::TICK_W;
   localparam int NS_W       = cstd_pkg::NS_W;
   localparam int FRAC_W     = cstd_pkg::FRAC_W;
   localparam int SHIFT_W    = cstd_pkg::SHIFT_W;
   localparam int CSR_IDX_W  = cstd_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = cstd_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W = cstd_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = cstd_pkg::RSP_DATA_W;
   localparam int RSP_PAD_W  = cstd_pkg::RSP_PAD_W;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD_CYCLES = 2000;
   localparam int DRAIN_CYCLES = 150;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [3:0]        pad;
      logic              scg1;
      logic              scg0;
      logic              osc_off;
      logic              cpu_off;
      logic [CYC_W-1:0]  cycles;
   } tick_req_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [TICK_W-1:0]    smclk;
      logic [TICK_W-1:0]    aclk;
      logic [CYC_W-1:0]     mclk;
      logic [TICK_W-1:0]    dco;
      logic [TICK_W-1:0]    xt2;
      logic [TICK_W-1:0]    lfxt1;
      logic [NS_W-1:0]      elapsed;
   } tick_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   clock_system_tick_distributor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor copy of the settings and of the running state
   logic [PER_W-1:0]       dco_period;
   logic [PER_W-1:0]       xt2_period;
   logic [PER_W-1:0]       lfxt1_period;
   cstd_pkg::mclk_src_type mclk_src;
   logic                   smclk_src;
   logic [5:0]             div_shifts;
   logic                   xt2_off_bit;
   logic [PER_W-1:0]       osc_rem_ns [3];
   logic [FRAC_W-1:0]      aclk_frac;
   logic [FRAC_W-1:0]      smclk_frac;

   tick_result_type expected_ticks_q [$];
   tick_result_type rsp_seen;
   tick_result_type rsp_want;
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   bit           gaps_enabled = 1'b1;
   logic         rsp_hold_req = 1'b0;
   int unsigned  rsp_hold_left = 0;
   int unsigned  rsp_stall_left = 0;

   function automatic void reset_model();
      dco_period   = PER_W'(cstd_pkg::DCO_PERIOD_RST);
      xt2_period   = PER_W'(cstd_pkg::XT2_PERIOD_RST);
      lfxt1_period = PER_W'(cstd_pkg::LFXT1_PERIOD_RST);
      mclk_src     = cstd_pkg::MCLK_DCO;
      smclk_src    = cstd_pkg::SMCLK_DCO;
      div_shifts   = '0;
      xt2_off_bit  = 1'b1;
      osc_rem_ns[cstd_pkg::OSC_LFXT1] = '0;
      osc_rem_ns[cstd_pkg::OSC_XT2]   = '0;
      osc_rem_ns[cstd_pkg::OSC_DCO]   = '0;
      aclk_frac    = '0;
      smclk_frac   = '0;
   endfunction

   function automatic void apply_setting(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] val);
      case (idx)
         cstd_pkg::CSR_DCO_PERIOD:     dco_period = val[PER_W-1:0];
         cstd_pkg::CSR_XT2_PERIOD:     xt2_period = val[PER_W-1:0];
         cstd_pkg::CSR_LFXT1_PERIOD:   lfxt1_period = val[PER_W-1:0];
         cstd_pkg::CSR_MCLK_SOURCE:    mclk_src = cstd_pkg::mclk_src_type'(val[1:0]);
         cstd_pkg::CSR_SMCLK_SOURCE:   smclk_src = val[0];
         cstd_pkg::CSR_DIVIDER_SHIFTS: div_shifts = val[5:0];
         cstd_pkg::CSR_XT2_OFF:        xt2_off_bit = val[0];
         default: ;
      endcase
   endfunction

   // adds ns to one oscillator's remainder, returns its whole ticks
   function automatic logic [TICK_W-1:0] share_ns(input cstd_pkg::osc_type osc,
                                                   input logic [PER_W-1:0] per,
                                                   input logic [63:0] ns);
      logic [63:0] acc;
      logic [63:0] quo;
      if (per == '0)
         return '0;
      acc = 64'(osc_rem_ns[osc]) + ns;
      osc_rem_ns[osc] = PER_W'(acc % 64'(per));
      quo = acc / 64'(per);
      return (quo > 64'(cstd_pkg::TICK_MAX)) ? cstd_pkg::TICK_MAX : quo[TICK_W-1:0];
   endfunction

   // returns {new fraction, divided ticks}
   function automatic logic [FRAC_W+TICK_W-1:0] divide_clock(input logic [FRAC_W-1:0] frac,
                                                            input logic [TICK_W-1:0] ticks,
                                                            input logic [SHIFT_W-1:0] shift);
      logic [63:0] sum;
      logic [63:0] quo;
      logic [63:0] mask;
      sum  = 64'(frac) + 64'(ticks);
      mask = (64'd1 << shift) - 64'd1;
      quo  = sum >> shift;
      return {FRAC_W'(sum & mask),
              (quo > 64'(cstd_pkg::TICK_MAX)) ? cstd_pkg::TICK_MAX : quo[TICK_W-1:0]};
   endfunction

   function automatic void predict_ticks(input tick_req_type s);
      logic [63:0] per;
      logic [63:0] ns;
      logic        lf_run;
      logic        xt2_run;
      logic        dco_run;
      logic        mclk_on_dco;
      logic [FRAC_W+TICK_W-1:0] div_out;
      tick_result_type r;
      case (mclk_src)
         cstd_pkg::MCLK_XT2:   per = 64'(xt2_period);
         cstd_pkg::MCLK_LFXT1: per = 64'(lfxt1_period);
         default:              per = 64'(dco_period);
      endcase
      ns = (64'(s.cycles) << div_shifts[3:2]) * per;
      if (ns > 64'(cstd_pkg::NS_MAX))
         ns = 64'(cstd_pkg::NS_MAX);
      r = '0;
      r.elapsed = ns[NS_W-1:0];
      mclk_on_dco = (mclk_src == cstd_pkg::MCLK_DCO) || (mclk_src == cstd_pkg::MCLK_DCO_ALT);
      lf_run  = !s.osc_off || (mclk_src == cstd_pkg::MCLK_LFXT1 && !s.cpu_off);
      xt2_run = !xt2_off_bit || (mclk_src == cstd_pkg::MCLK_XT2 && !s.cpu_off)
             || smclk_src == cstd_pkg::SMCLK_XT2;
      dco_run = !s.scg0 || (mclk_on_dco && !s.cpu_off) || smclk_src == cstd_pkg::SMCLK_DCO;
      if (lf_run)
         r.lfxt1 = share_ns(cstd_pkg::OSC_LFXT1, lfxt1_period, ns);
      if (xt2_run)
         r.xt2 = share_ns(cstd_pkg::OSC_XT2, xt2_period, ns);
      if (dco_run)
         r.dco = share_ns(cstd_pkg::OSC_DCO, dco_period, ns);
      r.mclk = s.cpu_off ? '0 : s.cycles;
      div_out = divide_clock(aclk_frac, r.lfxt1, div_shifts[1:0]);
      aclk_frac = div_out[FRAC_W+TICK_W-1:TICK_W];
      r.aclk = div_out[TICK_W-1:0];
      if (!s.scg1) begin
         div_out = divide_clock(smclk_frac,
                                (smclk_src == cstd_pkg::SMCLK_DCO) ? r.dco : r.xt2,
                                div_shifts[5:4]);
         smclk_frac = div_out[FRAC_W+TICK_W-1:TICK_W];
         r.smclk = div_out[TICK_W-1:0];
      end
      expected_ticks_q.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] seen);
      if (want !== seen) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected 0x%0h, got 0x%0h", name, want, seen);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen = tick_result_type'(rsp_tdata);
         if (expected_ticks_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected item on rsp: 0x%0h", rsp_tdata);
         end else begin
            rsp_want = expected_ticks_q.pop_front();
            check_field("elapsed_ns", 64'(rsp_want.elapsed), 64'(rsp_seen.elapsed));
            check_field("lfxt1_ticks", 64'(rsp_want.lfxt1), 64'(rsp_seen.lfxt1));
            check_field("xt2_ticks", 64'(rsp_want.xt2), 64'(rsp_seen.xt2));
            check_field("dco_ticks", 64'(rsp_want.dco), 64'(rsp_seen.dco));
            check_field("mclk_ticks", 64'(rsp_want.mclk), 64'(rsp_seen.mclk));
            check_field("aclk_ticks", 64'(rsp_want.aclk), 64'(rsp_seen.aclk));
            check_field("smclk_ticks", 64'(rsp_want.smclk), 64'(rsp_seen.smclk));
            check_field("pad", 64'(rsp_want.pad), 64'(rsp_seen.pad));
         end
      end
   end

   // receiver: random stall bursts, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_req) begin
         rsp_hold_left = LONG_HOLD_CYCLES;
         rsp_hold_req <= 1'b0;
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_step(input tick_req_type s);
      int gap;
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_ticks(s);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_setting(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering items and wait until every expected result is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_ticks_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_period();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 32'd1;
         2:       return $urandom_range(2, 64);
         3:       return $urandom_range(100, 40000);
         default: return $urandom;
      endcase
   endfunction

   function automatic tick_req_type random_step();
      tick_req_type s;
      s = '0;
      case ($urandom_range(0, 5))
         0:       s.cycles = '0;
         1:       s.cycles = '1;
         2, 3:    s.cycles = CYC_W'($urandom_range(1, 64));
         default: s.cycles = CYC_W'($urandom);
      endcase
      {s.scg1, s.scg0, s.osc_off, s.cpu_off} = 4'($urandom_range(0, 15));
      return s;
   endfunction

   task automatic randomize_settings();
      wait_idle();
      write_csr(cstd_pkg::CSR_DCO_PERIOD, random_period());
      write_csr(cstd_pkg::CSR_XT2_PERIOD, random_period());
      write_csr(cstd_pkg::CSR_LFXT1_PERIOD, random_period());
      write_csr(cstd_pkg::CSR_MCLK_SOURCE, $urandom);
      write_csr(cstd_pkg::CSR_SMCLK_SOURCE, $urandom);
      write_csr(cstd_pkg::CSR_DIVIDER_SHIFTS, $urandom);
      write_csr(cstd_pkg::CSR_XT2_OFF, $urandom);
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_UNUSED_IDX, $urandom);
   endtask

   // every flag combination at the reset settings; xt2 has no period here
   task automatic test_reset_defaults();
      tick_req_type s;
      for (int f = 0; f < 16; f++) begin
         s = '0;
         s.cycles = (f == 0) ? 16'h0000 : (f == 15) ? 16'hffff : 16'($urandom);
         {s.scg1, s.scg0, s.osc_off, s.cpu_off} = 4'(f);
         send_step(s);
      end
   endtask

   task automatic test_register_extremes();
      tick_req_type s;
      // slowest main source, fastest other clocks: tick counts saturate
      wait_idle();
      write_csr(cstd_pkg::CSR_LFXT1_PERIOD, 32'h00ff_ffff);
      write_csr(cstd_pkg::CSR_DCO_PERIOD, 32'd1);
      write_csr(cstd_pkg::CSR_XT2_PERIOD, 32'd1);
      write_csr(cstd_pkg::CSR_MCLK_SOURCE, CSR_DATA_W'(cstd_pkg::MCLK_LFXT1));
      write_csr(cstd_pkg::CSR_SMCLK_SOURCE, CSR_DATA_W'(cstd_pkg::SMCLK_XT2));
      write_csr(cstd_pkg::CSR_DIVIDER_SHIFTS, 32'h3f);
      write_csr(cstd_pkg::CSR_XT2_OFF, 32'd0);
      s = '0;
      s.cycles = 16'hffff;
      send_step(s);
      s.cpu_off = 1'b1;
      s.osc_off = 1'b1;
      s.scg0 = 1'b1;
      send_step(s);
      s.osc_off = 1'b0;
      s.scg1 = 1'b1;
      send_step(s);
      // bits above the period width dropped, unknown index ignored
      wait_idle();
      write_csr(CSR_UNUSED_IDX, 32'hffff_ffff);
      write_csr(cstd_pkg::CSR_DCO_PERIOD, 32'hff00_0000 | $urandom_range(1, 4000));
      write_csr(cstd_pkg::CSR_XT2_PERIOD, 32'hffff_ffff);
      write_csr(cstd_pkg::CSR_MCLK_SOURCE, CSR_DATA_W'(cstd_pkg::MCLK_DCO_ALT));
      write_csr(cstd_pkg::CSR_SMCLK_SOURCE, CSR_DATA_W'(cstd_pkg::SMCLK_DCO));
      write_csr(cstd_pkg::CSR_DIVIDER_SHIFTS, 32'h0);
      write_csr(cstd_pkg::CSR_XT2_OFF, 32'd1);
      s = '0;
      send_step(s);
      s.cycles = 16'd1;
      s.scg0 = 1'b1;
      send_step(s);
      s.cycles = 16'hffff;
      s.cpu_off = 1'b1;
      send_step(s);
      // main source with no period: no elapsed time
      wait_idle();
      write_csr(cstd_pkg::CSR_XT2_PERIOD, 32'd0);
      write_csr(cstd_pkg::CSR_MCLK_SOURCE, CSR_DATA_W'(cstd_pkg::MCLK_XT2));
      s = '0;
      s.cycles = 16'hffff;
      send_step(s);
      s.osc_off = 1'b1;
      send_step(s);
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 8; phase++) begin
         randomize_settings();
         gaps_enabled = ($urandom_range(0, 3) != 0);
         repeat (75) send_step(random_step());
      end
      gaps_enabled = 1'b1;
   endtask

   // receiver holds off long enough that the block stalls its input
   task automatic test_output_backpressure();
      randomize_settings();
      rsp_hold_req <= 1'b1;
      repeat (8) send_step(random_step());
      wait_idle();
      repeat (10) send_step(random_step());
   endtask

   task automatic test_steady_stream();
      gaps_enabled = 1'b0;
      randomize_settings();
      repeat (90) send_step(random_step());
   endtask

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_random_settings();
      test_output_backpressure();
      test_steady_stream();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_ticks_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cstd_pkg.sv
rtl/core/cstd_div.sv
rtl/core/cstd_dp.sv
rtl/core/cstd_ctl.sv
rtl/core/clock_system_tick_distributor.sv
rtl/core/cstd_checker.sv
verif/tb_clock_system_tick_distributor.sv
